>>> hw/rtl/assert_macros.svh
// Assertion macros used by lamport_mutex_node_core.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, skipped during reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// property checked on every rising clock edge, including reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed: label");

`endif

>>> hw/rtl/lmn_pkg.sv
// Types and constants for the Lamport mutual exclusion node.
// No dependencies.
`timescale 1ns / 1ps

package lmn_pkg;

   localparam int NODE_W = 4;

   typedef enum logic [2:0] {
      CMD_REQUEST   = 3'd0,
      CMD_ENTER     = 3'd1,
      CMD_RELEASE   = 3'd2,
      CMD_REMOTE    = 3'd3,
      CMD_TERMINATE = 3'd4
   } cmd_type;

   localparam logic [1:0] MSG_REQUEST = 2'd0;
   localparam logic [1:0] MSG_RELEASE = 2'd1;
   localparam logic [1:0] MSG_QUIT    = 2'd2;

   localparam logic [1:0] SEND_NONE      = 2'd0;
   localparam logic [1:0] SEND_REQUEST   = 2'd1;
   localparam logic [1:0] SEND_RELEASE   = 2'd2;
   localparam logic [1:0] SEND_TERMINATE = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_BAD  = 2'd2;

   localparam logic CSR_OWN_NODE   = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_GRANT
   } state_type;

   // queue cell control
   typedef struct packed {
      logic rem;
      logic ins;
   } q_ctl_type;

   // peer cell control
   typedef struct packed {
      logic upd;
      logic deact;
   } p_ctl_type;

endpackage

>>> hw/rtl/lmn_qcell.sv
// One slot of the sorted request queue; shifts with its neighbors.
// Depends on lmn_pkg.
`timescale 1ns / 1ps

module lmn_qcell #(
   parameter int IDX = 0,
   parameter int TW  = 32,
   parameter int CW  = 5
) (
   input  logic                      clock,
   input  lmn_pkg::q_ctl_type        ctl,
   input  logic [TW-1:0]             key_time,
   input  logic [lmn_pkg::NODE_W-1:0] key_node,
   input  logic [CW-1:0]             count,
   input  logic [TW-1:0]             prev_time,
   input  logic [lmn_pkg::NODE_W-1:0] prev_node,
   input  logic                      prev_less,
   input  logic                      prev_hit,
   input  logic [TW-1:0]             next_time,
   input  logic [lmn_pkg::NODE_W-1:0] next_node,
   output logic [TW-1:0]             ent_time,
   output logic [lmn_pkg::NODE_W-1:0] ent_node,
   output logic                      less,
   output logic                      hit
);
   logic [TW-1:0]              time_ff, time_in;
   logic [lmn_pkg::NODE_W-1:0] node_ff, node_in;
   logic                       valid;

   assign valid = CW'(IDX) < count;
   assign less  = valid && ((key_time != time_ff) ? (key_time < time_ff)
                                                  : (key_node < node_ff));
   assign hit   = prev_hit || (valid && node_ff == key_node);

   always_comb begin
      time_in = time_ff;
      node_in = node_ff;
      if (ctl.rem) begin
         if (hit) begin
            time_in = next_time;
            node_in = next_node;
         end
      end else if (ctl.ins) begin
         priority if (valid && !less) begin
            time_in = time_ff;
         end else if (prev_less) begin
            time_in = prev_time;
            node_in = prev_node;
         end else if (CW'(IDX) <= count) begin
            time_in = key_time;
            node_in = key_node;
         end
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      node_ff <= node_in;
   end

   assign ent_time = time_ff;
   assign ent_node = node_ff;
endmodule

>>> hw/rtl/lmn_pcell.sv
// Per-peer state: highest timestamp heard and active flag; grant term chains through.
// Depends on lmn_pkg.
`timescale 1ns / 1ps

module lmn_pcell #(
   parameter int IDX = 0,
   parameter int TW  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lmn_pkg::p_ctl_type        ctl,
   input  logic [lmn_pkg::NODE_W-1:0] sender,
   input  logic [TW-1:0]             msg_time,
   input  logic [TW-1:0]             own_time,
   input  logic [lmn_pkg::NODE_W-1:0] own_node,
   input  logic [7:0]                nodes_used,
   input  logic                      ok_in,
   output logic                      ok_out
);
   logic [TW-1:0] high_ff, high_in;
   logic          act_ff, act_in;
   logic          sel, later, skip;

   assign sel = 8'(IDX) == {4'b0, sender};

   always_comb begin
      high_in = high_ff;
      act_in  = act_ff;
      if (sel && ctl.upd && msg_time > high_ff) high_in = msg_time;
      if (sel && ctl.deact) act_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff <= '0;
         act_ff  <= 1'b1;
      end else begin
         high_ff <= high_in;
         act_ff  <= act_in;
      end
   end

   assign skip  = (8'(IDX) >= nodes_used) || (8'(IDX) == {4'b0, own_node}) || !act_ff;
   assign later = (high_ff > own_time) ||
                  (high_ff == own_time && 8'(IDX) > {4'b0, own_node});
   assign ok_out = ok_in && (skip || later);
endmodule

>>> hw/rtl/lamport_mutex_node_core.sv
// Lamport mutual exclusion node: one item at a time, in steps (accept, remove shift, insert
// shift, grant chain); the grant step loads the result into the output register, where it is
// held until taken. The next item may be accepted meanwhile; it stalls in its grant step
// while the previous result waits. Queue and peer rows are chains of cells updated in
// parallel. Synchronous reset clears clock, queue count, peer times, sets peers active,
// own_node 0, node_count 16.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lamport_mutex_node_core #(
   parameter int MAX_NODES = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cmd[2:0], msg_kind[4:3], sender[8:5], msg_time[40:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // grant[0], clock_now[32:1], send_kind[34:33], send_time[66:35], status[68:67]
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);
   localparam int TW = TIME_BITS;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int NW = lmn_pkg::NODE_W;

   lmn_pkg::state_type state_ff, state_in;

   logic [NW-1:0] own_node_ff;
   logic [4:0]    node_count_ff;
   logic [7:0]    nodes_used;

   logic [2:0]    cmd_ff;
   logic [1:0]    kind_ff;
   logic [NW-1:0] sender_ff;
   logic [TW-1:0] mtime_ff, mtime_in;

   logic [TW-1:0] clock_ff, clock_in;
   logic [TW-1:0] own_time_ff, own_time_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    send_kind_ff, send_kind_in;
   logic [1:0]    status_ff, status_in;

   logic          rsp_valid_ff;
   logic          grant_ff;
   logic [31:0]   clock_out_ff, send_time_ff;
   logic [1:0]    kind_out_ff, status_out_ff;
   logic [TW-1:0] send_time_in;
   logic [31:0]   clock_out_in, send_time_out_in;

   logic          bad_sender, remote_ok;
   logic [TW-1:0] clock_max;
   logic [TW:0]   sum1, sum2, sumr;
   logic [TW-1:0] clk_p1, clk_p2, clk_pr;

   lmn_pkg::q_ctl_type qctl;
   lmn_pkg::p_ctl_type pctl;
   logic [TW-1:0] key_time;
   logic [NW-1:0] key_node;

   logic [TW-1:0] q_time [MAX_NODES+1];
   logic [NW-1:0] q_node [MAX_NODES+1];
   logic          q_less [MAX_NODES+1];
   logic          q_hit  [MAX_NODES+1];
   logic          p_ok   [MAX_NODES+1];

   logic          req_accept, rsp_silent;

   // input timestamp fitted to the clock width, clock and send time outputs to 32 bits
   generate
      if (TW >= 32) begin : g_wide
         assign mtime_in = TW'(req_tdata[40:9]);
         assign clock_out_in = clock_ff[31:0];
         assign send_time_out_in = send_time_in[31:0];
      end else begin : g_narrow
         assign mtime_in = (|req_tdata[40:9+TW]) ? {TW{1'b1}} : req_tdata[9+TW-1:9];
         assign clock_out_in = 32'(clock_ff);
         assign send_time_out_in = 32'(send_time_in);
      end
   endgenerate

   assign nodes_used = (node_count_ff == 5'd0) ? 8'd1 :
                       ({3'b0, node_count_ff} > 8'(MAX_NODES)) ? 8'(MAX_NODES) :
                       {3'b0, node_count_ff};

   assign bad_sender = ({4'b0, sender_ff} >= nodes_used) || (sender_ff == own_node_ff) ||
                       ({4'b0, sender_ff} >= 8'(MAX_NODES));
   assign remote_ok  = (cmd_ff == lmn_pkg::CMD_REMOTE) && !bad_sender;

   assign clock_max = (clock_ff > mtime_ff) ? clock_ff : mtime_ff;
   assign sum1   = {1'b0, clock_ff} + (TW+1)'(1);
   assign sum2   = {1'b0, clock_ff} + (TW+1)'(2);
   assign sumr   = {1'b0, clock_max} + (TW+1)'(1);
   assign clk_p1 = sum1[TW] ? {TW{1'b1}} : sum1[TW-1:0];
   assign clk_p2 = sum2[TW] ? {TW{1'b1}} : sum2[TW-1:0];
   assign clk_pr = sumr[TW] ? {TW{1'b1}} : sumr[TW-1:0];

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff   <= '0;
         node_count_ff <= 5'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            lmn_pkg::CSR_OWN_NODE:   own_node_ff   <= csr_wdata[NW-1:0];
            lmn_pkg::CSR_NODE_COUNT: node_count_ff <= csr_wdata;
            default:                 own_node_ff   <= own_node_ff;
         endcase
      end
   end

   assign req_tready = (state_ff == lmn_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clock_in     = clock_ff;
      own_time_in  = own_time_ff;
      count_in     = count_ff;
      send_kind_in = send_kind_ff;
      status_in    = status_ff;
      qctl         = '0;
      pctl         = '0;
      key_time     = clock_ff;
      key_node     = own_node_ff;
      send_time_in = (send_kind_ff == lmn_pkg::SEND_NONE) ? '0 : clock_ff;
      if (remote_ok) begin
         key_time = mtime_ff;
         key_node = sender_ff;
      end
      unique case (state_ff)
         lmn_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lmn_pkg::ST_REMOVE;
         end
         lmn_pkg::ST_REMOVE: begin
            send_kind_in = lmn_pkg::SEND_NONE;
            status_in    = lmn_pkg::STAT_OK;
            unique case (cmd_ff)
               lmn_pkg::CMD_REQUEST: begin
                  clock_in     = clk_p2;
                  own_time_in  = clk_p2;
                  qctl.rem     = 1'b1;
                  send_kind_in = lmn_pkg::SEND_REQUEST;
               end
               lmn_pkg::CMD_ENTER: clock_in = clk_p1;
               lmn_pkg::CMD_RELEASE: begin
                  clock_in     = clk_p1;
                  qctl.rem     = 1'b1;
                  send_kind_in = lmn_pkg::SEND_RELEASE;
               end
               lmn_pkg::CMD_REMOTE: begin
                  if (bad_sender) begin
                     status_in = lmn_pkg::STAT_BAD;
                  end else begin
                     clock_in   = clk_pr;
                     pctl.upd   = (kind_ff == lmn_pkg::MSG_REQUEST) ||
                                  (kind_ff == lmn_pkg::MSG_RELEASE);
                     pctl.deact = (kind_ff == lmn_pkg::MSG_QUIT);
                     qctl.rem   = (kind_ff == lmn_pkg::MSG_RELEASE);
                  end
               end
               lmn_pkg::CMD_TERMINATE: send_kind_in = lmn_pkg::SEND_TERMINATE;
               default: clock_in = clock_ff;
            endcase
            if (qctl.rem && q_hit[MAX_NODES]) count_in = count_ff - CW'(1);
            state_in = lmn_pkg::ST_INSERT;
         end
         lmn_pkg::ST_INSERT: begin
            if ((cmd_ff == lmn_pkg::CMD_REQUEST) ||
                (remote_ok && kind_ff == lmn_pkg::MSG_REQUEST)) begin
               if (count_ff < CW'(MAX_NODES)) begin
                  qctl.ins = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  status_in = lmn_pkg::STAT_FULL;
                  if (cmd_ff == lmn_pkg::CMD_REQUEST) send_kind_in = lmn_pkg::SEND_NONE;
               end
            end
            state_in = lmn_pkg::ST_GRANT;
         end
         lmn_pkg::ST_GRANT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) state_in = lmn_pkg::ST_IDLE;
         end
         default: state_in = lmn_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lmn_pkg::ST_IDLE;
         clock_ff    <= '0;
         own_time_ff <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clock_ff    <= clock_in;
         own_time_ff <= own_time_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      send_kind_ff <= send_kind_in;
      status_ff    <= status_in;
      if (req_tvalid && req_tready) begin
         cmd_ff    <= req_tdata[2:0];
         kind_ff   <= req_tdata[4:3];
         sender_ff <= req_tdata[8:5];
         mtime_ff  <= mtime_in;
      end
   end

   // queue and peer rows
   assign q_time[0] = key_time;
   assign q_node[0] = key_node;
   assign q_less[0] = 1'b0;
   assign q_hit[0]  = 1'b0;
   assign p_ok[0]   = 1'b1;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_NODES; gi++) begin : g_cells
         logic [TW-1:0] nxt_time;
         logic [NW-1:0] nxt_node;
         if (gi + 1 < MAX_NODES) begin : g_mid
            assign nxt_time = q_time[gi+2];
            assign nxt_node = q_node[gi+2];
         end else begin : g_end
            assign nxt_time = key_time;
            assign nxt_node = key_node;
         end

         lmn_qcell #(.IDX(gi), .TW(TW), .CW(CW)) u_q (
            .clock     (clock),
            .ctl       (qctl),
            .key_time  (key_time),
            .key_node  (key_node),
            .count     (count_ff),
            .prev_time (q_time[gi]),
            .prev_node (q_node[gi]),
            .prev_less (q_less[gi]),
            .prev_hit  (q_hit[gi]),
            .next_time (nxt_time),
            .next_node (nxt_node),
            .ent_time  (q_time[gi+1]),
            .ent_node  (q_node[gi+1]),
            .less      (q_less[gi+1]),
            .hit       (q_hit[gi+1])
         );

         lmn_pcell #(.IDX(gi), .TW(TW)) u_p (
            .clock      (clock),
            .reset      (reset),
            .ctl        (pctl),
            .sender     (sender_ff),
            .msg_time   (mtime_ff),
            .own_time   (own_time_ff),
            .own_node   (own_node_ff),
            .nodes_used (nodes_used),
            .ok_in      (p_ok[gi]),
            .ok_out     (p_ok[gi+1])
         );
      end
   endgenerate

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == lmn_pkg::ST_GRANT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lmn_pkg::ST_GRANT && (!rsp_valid_ff || rsp_tready)) begin
         grant_ff      <= (count_ff != '0) && (q_node[1] == own_node_ff) && p_ok[MAX_NODES];
         clock_out_ff  <= clock_out_in;
         send_time_ff  <= send_time_out_in;
         kind_out_ff   <= send_kind_ff;
         status_out_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, status_out_ff, send_time_ff, kind_out_ff, clock_out_ff, grant_ff};

   assign req_accept = req_tvalid && req_tready;
   assign rsp_silent = rsp_tvalid && (kind_out_ff == lmn_pkg::SEND_NONE);

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CW'(MAX_NODES))
   `ASSERT_CLK(a_accept_starts, clock, reset, req_accept |=> (state_ff == lmn_pkg::ST_REMOVE))
   `ASSERT_CLK(a_no_send_zero_time, clock, reset, rsp_silent |-> (send_time_ff == 32'd0))
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
endmodule

>>> verif/lamport_mutex_node_core_tb.sv
// Self-checking testbench for lamport_mutex_node_core: drives stream items and CSR writes,
// predicts each result with a scoreboard class and compares it field by field.
// Depends on lmn_pkg and the lamport_mutex_node_core RTL.
`timescale 1ns / 1ps

module lamport_mutex_node_core_tb;

   localparam int LIMIT = 600000;

   // codes outside the defined ranges
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] CMD_BAD_LO  = 3'd5;
   localparam logic [2:0] CMD_BAD_HI  = 3'd7;

   typedef struct {
      logic        grant;
      logic [31:0] clock_now;
      logic [1:0]  send_kind;
      logic [31:0] send_time;
      logic [1:0]  status;
   } node_rsp_type;

   class mutex_scoreboard;
      node_rsp_type pending[$];
      int          errors;
      logic [3:0]  own;
      logic [4:0]  ncount;
      logic [31:0] lclock, own_time;
      logic [31:0] q_time[16];
      logic [3:0]  q_node[16];
      int          q_cnt;
      logic [31:0] peer_time[16];
      bit          peer_on[16];

      function new();
         errors = 0;
         own = 4'd0;
         ncount = 5'd16;
         lclock = 32'd0;
         own_time = 32'd0;
         q_cnt = 0;
         for (int i = 0; i < 16; i++) begin
            peer_time[i] = 32'd0;
            peer_on[i] = 1;
         end
      endfunction

      function void write_csr(logic idx, logic [4:0] val);
         if (idx == lmn_pkg::CSR_OWN_NODE) own = val[3:0];
         else ncount = val;
      endfunction

      function int nodes_used();
         if (ncount < 5'd1) return 1;
         if (ncount > 5'd16) return 16;
         return int'(ncount);
      endfunction

      function logic [31:0] sat_add(logic [31:0] a, logic [31:0] k);
         logic [32:0] s;
         s = {1'b0, a} + {1'b0, k};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function bit queue_add(logic [31:0] t, logic [3:0] n);
         int pos;
         if (q_cnt >= 16) return 0;
         pos = q_cnt;
         for (int i = 0; i < q_cnt; i++)
            if ((t != q_time[i]) ? (t < q_time[i]) : (n < q_node[i])) begin
               pos = i;
               break;
            end
         for (int i = q_cnt; i > pos; i--) begin
            q_time[i] = q_time[i-1];
            q_node[i] = q_node[i-1];
         end
         q_time[pos] = t;
         q_node[pos] = n;
         q_cnt++;
         return 1;
      endfunction

      function void queue_drop(logic [3:0] n);
         for (int i = 0; i < q_cnt; i++)
            if (q_node[i] == n) begin
               for (int j = i; j + 1 < q_cnt; j++) begin
                  q_time[j] = q_time[j+1];
                  q_node[j] = q_node[j+1];
               end
               q_cnt--;
               return;
            end
      endfunction

      function bit granted();
         if (q_cnt == 0 || q_node[0] != own) return 0;
         for (int i = 0; i < nodes_used(); i++) begin
            if (i == int'(own) || !peer_on[i]) continue;
            if (!(peer_time[i] > own_time || (peer_time[i] == own_time && i > int'(own))))
               return 0;
         end
         return 1;
      endfunction

      // compute the result of one accepted item and queue it
      function void note_item(logic [47:0] d);
         node_rsp_type r;
         logic [2:0]  cmd;
         logic [1:0]  kind;
         logic [3:0]  snd;
         logic [31:0] t;
         cmd = d[2:0];
         kind = d[4:3];
         snd = d[8:5];
         t = d[40:9];
         r.send_kind = lmn_pkg::SEND_NONE;
         r.send_time = 32'd0;
         r.status = lmn_pkg::STAT_OK;
         case (cmd)
            lmn_pkg::CMD_REQUEST: begin
               lclock = sat_add(lclock, 32'd2);
               own_time = lclock;
               queue_drop(own);
               if (queue_add(lclock, own)) begin
                  r.send_kind = lmn_pkg::SEND_REQUEST;
                  r.send_time = lclock;
               end else r.status = lmn_pkg::STAT_FULL;
            end
            lmn_pkg::CMD_ENTER: lclock = sat_add(lclock, 32'd1);
            lmn_pkg::CMD_RELEASE: begin
               lclock = sat_add(lclock, 32'd1);
               queue_drop(own);
               r.send_kind = lmn_pkg::SEND_RELEASE;
               r.send_time = lclock;
            end
            lmn_pkg::CMD_REMOTE: begin
               if (int'(snd) >= nodes_used() || snd == own) r.status = lmn_pkg::STAT_BAD;
               else begin
                  lclock = sat_add((lclock > t) ? lclock : t, 32'd1);
                  if ((kind == lmn_pkg::MSG_REQUEST || kind == lmn_pkg::MSG_RELEASE) &&
                      t > peer_time[snd])
                     peer_time[snd] = t;
                  if (kind == lmn_pkg::MSG_REQUEST) begin
                     if (!queue_add(t, snd)) r.status = lmn_pkg::STAT_FULL;
                  end else if (kind == lmn_pkg::MSG_RELEASE) queue_drop(snd);
                  else if (kind == lmn_pkg::MSG_QUIT) peer_on[snd] = 0;
               end
            end
            lmn_pkg::CMD_TERMINATE: begin
               r.send_kind = lmn_pkg::SEND_TERMINATE;
               r.send_time = lclock;
            end
            default: ;
         endcase
         r.grant = granted();
         r.clock_now = lclock;
         pending.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
         errors++;
      endtask

      task check_rsp(logic [71:0] d);
         node_rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected result", d[31:0], 32'd0);
            return;
         end
         e = pending.pop_front();
         if (d[0] !== e.grant) report("grant", 32'(d[0]), 32'(e.grant));
         if (d[32:1] !== e.clock_now) report("clock_now", d[32:1], e.clock_now);
         if (d[34:33] !== e.send_kind) report("send_kind", 32'(d[34:33]), 32'(e.send_kind));
         if (d[66:35] !== e.send_time) report("send_time", d[66:35], e.send_time);
         if (d[68:67] !== e.status) report("status", 32'(d[68:67]), 32'(e.status));
      endtask
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_we, csr_index;
   logic [4:0]  csr_wdata;

   mutex_scoreboard sb;
   int snd_idle, rcv_idle, cycles;

   lamport_mutex_node_core i_dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      rsp_tready = 0;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = '0;
      snd_idle = 0;
      rcv_idle = 0;
      cycles = 0;
      sb = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // take results; the stall rate follows the current phase
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else begin
         if (rsp_tvalid && rsp_tready) sb.check_rsp(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   function automatic logic [47:0] pack_item(logic [2:0] c, logic [1:0] k, logic [3:0] s,
                                             logic [31:0] t);
      return {7'd0, t, s, k, c};
   endfunction

   task automatic push_item(logic [47:0] d);
      req_tvalid <= 1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(d);
      if ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending and hold until every result is back
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_csr(idx, val);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int          p;
      logic [2:0]  c;
      logic [1:0]  k;
      logic [3:0]  s;
      logic [31:0] t;
      p = $urandom_range(99);
      k = 2'($urandom);
      s = 4'($urandom);
      t = $urandom;
      if (p < 15) c = lmn_pkg::CMD_REQUEST;
      else if (p < 23) c = lmn_pkg::CMD_ENTER;
      else if (p < 33) c = lmn_pkg::CMD_RELEASE;
      else if (p < 35) c = lmn_pkg::CMD_TERMINATE;
      else if (p < 40) c = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      else begin
         c = lmn_pkg::CMD_REMOTE;
         p = $urandom_range(99);
         k = (p < 50) ? lmn_pkg::MSG_REQUEST : (p < 93) ? lmn_pkg::MSG_RELEASE :
             (p < 96) ? lmn_pkg::MSG_QUIT : KIND_UNUSED;
         if ($urandom_range(9) != 0) begin
            s = 4'($urandom_range(sb.nodes_used() - 1));
            if (s == sb.own) s = s + 4'd1;
         end
         p = $urandom_range(99);
         if (p < 60) t = sb.lclock + 32'($urandom_range(0, 6));
         else if (p < 97) t = sb.lclock - 32'($urandom_range(0, 6));
      end
      push_item(pack_item(c, k, s, t));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every command and message kind, a full queue, clamped counts
      write_csr(lmn_pkg::CSR_OWN_NODE, 5'd0);
      write_csr(lmn_pkg::CSR_NODE_COUNT, 5'd16);
      push_item(pack_item(lmn_pkg::CMD_REQUEST, 2'd0, 4'd0, 32'd0));
      push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_REQUEST, 4'd1, 32'd0));
      push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_RELEASE, 4'd1, 32'd9));
      push_item(pack_item(lmn_pkg::CMD_ENTER, 2'd0, 4'd0, 32'd0));
      push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_QUIT, 4'd2, 32'd3));
      push_item(pack_item(lmn_pkg::CMD_REMOTE, KIND_UNUSED, 4'd15, 32'd40));
      push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_REQUEST, 4'd0, 32'd50));
      push_item(pack_item(lmn_pkg::CMD_RELEASE, 2'd0, 4'd0, 32'd0));
      push_item(pack_item(lmn_pkg::CMD_TERMINATE, 2'd0, 4'd0, 32'd0));
      push_item(pack_item(CMD_BAD_LO, KIND_UNUSED, 4'hF, 32'hFFFF_FFFF));
      push_item(pack_item(CMD_BAD_HI, 2'd0, 4'd0, 32'd0));
      for (int i = 0; i < 17; i++)
         push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_REQUEST, 4'd1, 32'(60 + i)));
      push_item(pack_item(lmn_pkg::CMD_REQUEST, 2'd0, 4'd0, 32'd0));
      for (int i = 0; i < 17; i++)
         push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_RELEASE, 4'd1, 32'd90));
      drain();
      write_csr(lmn_pkg::CSR_NODE_COUNT, 5'd0);
      push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_REQUEST, 4'd1, 32'd95));
      drain();
      write_csr(lmn_pkg::CSR_NODE_COUNT, 5'd31);
      write_csr(lmn_pkg::CSR_OWN_NODE, 5'd15);
      push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_REQUEST, 4'd15, 32'd99));
      push_item(pack_item(lmn_pkg::CMD_REQUEST, 2'd0, 4'd0, 32'd0));
      drain();

      snd_idle = 10;
      rcv_idle = 46;
      write_csr(lmn_pkg::CSR_OWN_NODE, 5'd3);
      write_csr(lmn_pkg::CSR_NODE_COUNT, 5'd16);
      repeat (560) random_item();
      drain();

      snd_idle = 46;
      rcv_idle = 10;
      write_csr(lmn_pkg::CSR_OWN_NODE, 5'd0);
      write_csr(lmn_pkg::CSR_NODE_COUNT, 5'd5);
      repeat (280) random_item();
      // pause the sender until every result is in
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (280) random_item();
      drain();

      snd_idle = 0;
      rcv_idle = 0;
      write_csr(lmn_pkg::CSR_OWN_NODE, 5'd15);
      write_csr(lmn_pkg::CSR_NODE_COUNT, 5'd16);
      repeat (560) random_item();
      // saturate the clock
      push_item(pack_item(lmn_pkg::CMD_REMOTE, lmn_pkg::MSG_REQUEST, 4'd1, 32'hFFFF_FFFF));
      push_item(pack_item(lmn_pkg::CMD_REQUEST, 2'd0, 4'd0, 32'd0));
      push_item(pack_item(lmn_pkg::CMD_ENTER, 2'd0, 4'd0, 32'd0));
      push_item(pack_item(lmn_pkg::CMD_RELEASE, 2'd0, 4'd0, 32'd0));
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

>>> lamport_mutex_node_core.f
+incdir+hw/rtl
hw/rtl/lmn_pkg.sv
hw/rtl/lmn_qcell.sv
hw/rtl/lmn_pcell.sv
hw/rtl/lamport_mutex_node_core.sv
verif/lamport_mutex_node_core_tb.sv
